// ===== hdl/query_language_token_scanner_defines.svh =====
// Assertion macros shared by the scanner's checker.
// No dependencies; included by files that carry assertions.
`ifndef QUERY_LANGUAGE_TOKEN_SCANNER_DEFINES_SVH
`define QUERY_LANGUAGE_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define QLTS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qlts: same-cycle check failed");

// next-cycle implication, reset masks the check
`define QLTS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qlts: next-cycle check failed");

`endif

// ===== hdl/qlts_pkg.sv =====
// Shared types, constants and the keyword table of the token scanner.
// No dependencies.
`default_nettype none

package qlts_pkg;

  localparam int unsigned MAX_LINE     = 256;
  localparam int unsigned COL_W        = $clog2(MAX_LINE + 1);
  localparam int unsigned PREFIX_BYTES = 7;
  localparam int unsigned PREFIX_W     = 8 * PREFIX_BYTES;
  localparam int unsigned NUM_KW       = 14;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef logic [COL_W-1:0] col_t;

  localparam col_t COL_MAX = col_t'(MAX_LINE);

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_REGEX   = 3'd3,
    KIND_PUNCT   = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  keyword_index;
    logic [7:0]  punct_char;
    logic [15:0] row;
    logic [7:0]  col;
    logic [7:0]  length;
    logic        last;
  } tok_t;

  // up to two tokens per processed byte
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_hit_t;

  // word prefix layout: first byte in the top lane, unused lanes zero
  localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KW] = '{
    {"create", 8'h00},
    {"view", 24'h0},
    {"as", 40'h0},
    {"output", 8'h00},
    {"select", 8'h00},
    {"from", 24'h0},
    {"extract"},
    {"regex", 16'h0},
    {"on", 40'h0},
    {"return", 8'h00},
    {"group", 16'h0},
    {"and", 32'h0},
    {"Token", 16'h0},
    {"pattern"}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd6, 3'd4, 3'd2, 3'd6, 3'd6, 3'd4, 3'd7,
    3'd5, 3'd2, 3'd6, 3'd5, 3'd3, 3'd5, 3'd7
  };

  function automatic kw_hit_t kw_lookup(input logic [PREFIX_W-1:0] prefix,
                                        input logic [2:0] len);
    kw_hit_t r;
    r = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (KW_TEXT[i] == prefix && KW_LEN[i] == len) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qlts_if.sv =====
// Handshake channels of the token scanner: text bytes in, tokens out.
// No dependencies.
`default_nettype none

interface qlts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface qlts_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  keyword_index;
  logic [7:0]  punct_char;
  logic [15:0] row;
  logic [7:0]  col;
  logic [7:0]  length;
  logic        last;

  modport source (output valid, output kind, output keyword_index, output punct_char,
                  output row, output col, output length, output last, input ready);
  modport sink (input valid, input kind, input keyword_index, input punct_char,
                input row, input col, input length, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/qlts_scan_core.sv =====
// Input byte register, scanner state and token formation for one byte per cycle.
// Stalls while room_i is low. Depends on qlts_pkg and qlts_char_if.
`default_nettype none

module qlts_scan_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  qlts_char_if.sink         char_i,
  input  logic              room_i,
  output qlts_pkg::push_t   push_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_REGEX,
    MODE_STOP
  } mode_e;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  logic                              in_valid_q;
  logic [7:0]                        ch_q;
  mode_e                             mode_q, mode_d;
  logic [15:0]                       line_q, line_d;
  qlts_pkg::col_t                    column_q, column_d;
  qlts_pkg::col_t                    tstart_q, tstart_d;
  logic [qlts_pkg::PREFIX_W-1:0]     prefix_q, prefix_d;
  logic                              id_ok_q, id_ok_d;
  logic                              dig_ok_q, dig_ok_d;
  logic                              bs_q, bs_d;

  logic                              fire;
  qlts_pkg::col_t                    word_len;
  qlts_pkg::col_t                    rx_len;
  qlts_pkg::col_t                    cur_len;
  qlts_pkg::kw_hit_t                 kw;
  logic                              kw_hit;
  logic                              word_bad;
  logic                              is_space, is_punct, is_alpha, is_digit;
  logic                              start;
  qlts_pkg::tok_t                    word_tok, punct_tok, regex_tok, rx_err_tok, long_tok;

  assign fire         = in_valid_q && room_i;
  assign char_i.ready = !in_valid_q || room_i;

  assign word_len = column_q - tstart_q;
  assign rx_len   = column_q - tstart_q - qlts_pkg::col_t'(1);
  assign kw       = qlts_pkg::kw_lookup(prefix_q, word_len[2:0]);
  assign kw_hit   = kw.hit && (word_len <= qlts_pkg::col_t'(qlts_pkg::PREFIX_BYTES));
  assign word_bad = !kw_hit && !id_ok_q && !dig_ok_q;

  always_comb begin
    is_space = (ch_q == CH_SPACE) || (ch_q == CH_TAB) || (ch_q == CH_NUL);
    // . ( ) < > { } ; ,
    is_punct = ch_q inside {8'h2e, 8'h28, 8'h29, 8'h3c, 8'h3e, 8'h7b, 8'h7d, 8'h3b, 8'h2c};
    is_alpha = ch_q inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h5f};
    is_digit = ch_q inside {[8'h30:8'h39]};
  end

  always_comb begin
    word_tok = '{kind: kw_hit ? qlts_pkg::KIND_KEYWORD :
                       id_ok_q ? qlts_pkg::KIND_IDENT :
                       dig_ok_q ? qlts_pkg::KIND_NUMBER : qlts_pkg::KIND_ERROR,
                 keyword_index: kw_hit ? kw.idx : 4'd0,
                 punct_char: 8'd0, row: line_q, col: 8'(tstart_q),
                 length: 8'(word_len), last: 1'b0};
    punct_tok = '{kind: qlts_pkg::KIND_PUNCT, keyword_index: 4'd0, punct_char: ch_q,
                  row: line_q, col: 8'(column_q), length: 8'd1, last: 1'b0};
    regex_tok = '{kind: qlts_pkg::KIND_REGEX, keyword_index: 4'd0, punct_char: 8'd0,
                  row: line_q, col: 8'(tstart_q), length: 8'(rx_len), last: 1'b0};
    rx_err_tok = regex_tok;
    rx_err_tok.kind = qlts_pkg::KIND_ERROR;
    long_tok = '{kind: qlts_pkg::KIND_ERROR, keyword_index: 4'd0, punct_char: 8'd0,
                 row: line_q, col: 8'(column_q), length: 8'd0, last: 1'b0};
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    column_d = column_q;
    tstart_d = tstart_q;
    prefix_d = prefix_q;
    id_ok_d  = id_ok_q;
    dig_ok_d = dig_ok_q;
    bs_d     = bs_q;
    start    = (mode_q == MODE_IDLE);
    cur_len  = start ? '0 : word_len;
    push_o.count = 2'd0;
    push_o.tok0  = word_tok;
    push_o.tok1  = punct_tok;

    if (fire && mode_q != MODE_STOP) begin
      if (ch_q == CH_NL) begin
        if (mode_q == MODE_WORD) begin
          push_o.count = 2'd1;
        end else if (mode_q == MODE_REGEX) begin
          // newline inside a regex: unterminated
          push_o.tok0  = rx_err_tok;
          push_o.count = 2'd1;
        end
        if (mode_q == MODE_REGEX || (mode_q == MODE_WORD && word_bad)) begin
          mode_d = MODE_STOP;
        end else begin
          if (line_q != 16'hffff) begin
            line_d = line_q + 16'd1;
          end
          column_d = '0;
          mode_d   = MODE_IDLE;
        end
      end else if (column_q >= qlts_pkg::COL_MAX) begin
        push_o.tok0  = long_tok;
        push_o.count = 2'd1;
        mode_d       = MODE_STOP;
      end else if (mode_q == MODE_REGEX) begin
        column_d = column_q + qlts_pkg::col_t'(1);
        if (ch_q == CH_SLASH && !bs_q) begin
          push_o.tok0  = regex_tok;
          push_o.count = 2'd1;
          mode_d       = MODE_IDLE;
        end else begin
          bs_d = (ch_q == CH_BSLASH);
        end
      end else if (is_space) begin
        column_d = column_q + qlts_pkg::col_t'(1);
        if (mode_q == MODE_WORD) begin
          push_o.count = 2'd1;
          mode_d       = word_bad ? MODE_STOP : MODE_IDLE;
        end
      end else if (is_punct) begin
        column_d = column_q + qlts_pkg::col_t'(1);
        if (mode_q == MODE_WORD) begin
          push_o.count = 2'd1;
          if (word_bad) begin
            mode_d = MODE_STOP;
          end else begin
            push_o.count = 2'd2;
            mode_d       = MODE_IDLE;
          end
        end else begin
          push_o.tok0  = punct_tok;
          push_o.count = 2'd1;
        end
      end else if (ch_q == CH_SLASH) begin
        column_d = column_q + qlts_pkg::col_t'(1);
        if (mode_q == MODE_WORD) begin
          push_o.count = 2'd1;
        end
        if (mode_q == MODE_WORD && word_bad) begin
          mode_d = MODE_STOP;
        end else begin
          mode_d   = MODE_REGEX;
          tstart_d = column_q;
          bs_d     = 1'b0;
        end
      end else begin
        // word byte: open a word if none, keep the first bytes and shape flags
        column_d = column_q + qlts_pkg::col_t'(1);
        prefix_d = start ? '0 : prefix_q;
        for (int j = 0; j < qlts_pkg::PREFIX_BYTES; j++) begin
          if (cur_len == qlts_pkg::col_t'(j)) begin
            prefix_d[qlts_pkg::PREFIX_W-1-8*j -: 8] = ch_q;
          end
        end
        if (cur_len == '0) begin
          id_ok_d = is_alpha;
        end else begin
          id_ok_d = id_ok_q && (is_alpha || is_digit);
        end
        dig_ok_d = (start || dig_ok_q) && is_digit;
        if (start) begin
          mode_d   = MODE_WORD;
          tstart_d = column_q;
        end
      end
    end

    if (push_o.count == 2'd1) begin
      push_o.tok0.last = 1'b1;
    end else if (push_o.count == 2'd2) begin
      push_o.tok1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ch_q       <= '0;
      mode_q     <= MODE_IDLE;
      line_q     <= 16'd1;
      column_q   <= '0;
      tstart_q   <= '0;
      prefix_q   <= '0;
      id_ok_q    <= 1'b1;
      dig_ok_q   <= 1'b1;
      bs_q       <= 1'b0;
    end else begin
      if (char_i.ready) begin
        in_valid_q <= char_i.valid;
        if (char_i.valid) begin
          ch_q <= char_i.ch;
        end
      end
      mode_q   <= mode_d;
      line_q   <= line_d;
      column_q <= column_d;
      tstart_q <= tstart_d;
      prefix_q <= prefix_d;
      id_ok_q  <= id_ok_d;
      dig_ok_q <= dig_ok_d;
      bs_q     <= bs_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qlts_tok_fifo.sv =====
// Result register queue: takes up to two tokens a cycle, gives one a cycle.
// Output waits on tok_o.ready. Depends on qlts_pkg and qlts_tok_if.
`default_nettype none

module qlts_tok_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qlts_pkg::push_t   push_i,
  output logic              room_o,
  qlts_tok_if.source        tok_o
);

  qlts_pkg::tok_t                      mem_q [qlts_pkg::FIFO_DEPTH];
  logic [qlts_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [qlts_pkg::FIFO_PTR_W-1:0]     wr_ptr_nx;
  logic [qlts_pkg::FIFO_CNT_W-1:0]     count_q;
  logic                                pop;
  qlts_pkg::tok_t                      head;

  assign pop       = tok_o.valid && tok_o.ready;
  assign wr_ptr_nx = wr_ptr_q + qlts_pkg::FIFO_PTR_W'(1);
  // room for a worst-case byte (two tokens)
  assign room_o    = count_q <= qlts_pkg::FIFO_CNT_W'(qlts_pkg::FIFO_DEPTH - 2);

  assign head                = mem_q[rd_ptr_q];
  assign tok_o.valid         = (count_q != '0);
  assign tok_o.kind          = head.kind;
  assign tok_o.keyword_index = head.keyword_index;
  assign tok_o.punct_char    = head.punct_char;
  assign tok_o.row           = head.row;
  assign tok_o.col           = head.col;
  assign tok_o.length        = head.length;
  assign tok_o.last          = head.last;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + qlts_pkg::FIFO_PTR_W'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + qlts_pkg::FIFO_PTR_W'(1);
      end
      count_q <= count_q + qlts_pkg::FIFO_CNT_W'(push_i.count)
                 - qlts_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/query_language_token_scanner.sv =====
// One byte per cycle while the token queue has room; the token side drains one token
// per cycle, so a byte that gives a word and a punctuation token is absorbed by the
// four-entry token queue. Reset (async, low) sets row 1, column 0, no open word.
// An error token stops scanning: later bytes are taken and give no tokens until reset.
`default_nettype none

module query_language_token_scanner (
  input  logic         clk_i,
  input  logic         rst_ni,
  qlts_char_if.sink    char_i,
  qlts_tok_if.source   tok_o
);

  qlts_pkg::push_t push;
  logic            room;

  qlts_scan_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .room_i (room),
    .push_o (push)
  );

  qlts_tok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (tok_o)
  );

endmodule

`default_nettype wire

// ===== hdl/qlts_checker.sv =====
// Port-level checks on the scanner's token output, bound to the top level.
// Depends on qlts_pkg and query_language_token_scanner_defines.svh.
`default_nettype none
`include "query_language_token_scanner_defines.svh"

module qlts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        v_i,
  input logic        r_i,
  input logic [2:0]  kind_i,
  input logic [3:0]  kw_i,
  input logic [7:0]  pc_i,
  input logic [15:0] row_i,
  input logic [7:0]  col_i,
  input logic [7:0]  len_i,
  input logic        last_i
);

  logic [47:0] pay;
  logic        is_kw, is_pc, is_err;

  assign pay    = {kind_i, kw_i, pc_i, row_i, col_i, len_i, last_i};
  assign is_kw  = (kind_i == qlts_pkg::KIND_KEYWORD);
  assign is_pc  = (kind_i == qlts_pkg::KIND_PUNCT);
  assign is_err = (kind_i == qlts_pkg::KIND_ERROR);

  `QLTS_ASSERT_NXT(a_hold, clk_i, rst_ni, v_i && !r_i, v_i && $stable(pay))
  `QLTS_ASSERT_IMP(a_kw_zero, clk_i, rst_ni, v_i && !is_kw, kw_i == 4'd0)
  `QLTS_ASSERT_IMP(a_pc_zero, clk_i, rst_ni, v_i && !is_pc, pc_i == 8'd0)
  `QLTS_ASSERT_IMP(a_pc_len, clk_i, rst_ni, v_i && is_pc, len_i == 8'd1 && pc_i != 8'd0)
  `QLTS_ASSERT_IMP(a_err_last, clk_i, rst_ni, v_i && is_err, last_i)

endmodule

bind query_language_token_scanner qlts_checker u_qlts_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .v_i    (tok_o.valid),
  .r_i    (tok_o.ready),
  .kind_i (tok_o.kind),
  .kw_i   (tok_o.keyword_index),
  .pc_i   (tok_o.punct_char),
  .row_i  (tok_o.row),
  .col_i  (tok_o.col),
  .len_i  (tok_o.length),
  .last_i (tok_o.last)
);

`default_nettype wire
